/* src/assert_macros.svh */
// Concurrent assertion helpers, clocked on i_clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_CHK(lbl, prop, msg) `ASSERT_IMPL(lbl, i_clk, i_rst_n, prop, msg)

`endif

/* src/btrt_pkg.sv */
package btrt_pkg;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int TICK_W = 16;
    localparam int FREQ_W = 8;
    localparam int LOCK_W = 8;

    localparam int DIV_STEPS = TICK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = FREQ_W + 2;

    localparam logic [LOCK_W-1:0] LOCK_RST    = 8'd50;
    localparam logic [TICK_W-1:0] REPORT_RST  = 16'd5000;
    localparam logic [TICK_W-1:0] TPS_RST     = 16'd1000;
    localparam logic [FREQ_W-1:0] MIN_F_RST   = 8'd1;
    localparam logic [FREQ_W-1:0] MAX_F_RST   = 8'd255;
    localparam logic [FREQ_W-1:0] FREQ_RST    = 8'd3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LOCKOUT  = 3'd0,
        CFG_REPORT   = 3'd1,
        CFG_TPS      = 3'd2,
        CFG_MIN_FREQ = 3'd3,
        CFG_MAX_FREQ = 3'd4
    } t_cfg_addr;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

/* src/btrt_ctrl.sv */
`include "assert_macros.svh"

module btrt_ctrl
    import btrt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd.start  = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `ASSERT_CHK(a_start_enters_div, o_cmd.start |=> (r_state == S_DIV && r_cnt == '0), "start did not enter divide")
    `ASSERT_CHK(a_fin_after_steps, (r_state == S_FIN) |-> (r_cnt == '0), "divide step count wrong")

endmodule

/* src/btrt_datapath.sv */
`include "assert_macros.svh"

module btrt_datapath
    import btrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_up_level,
    input  logic                  i_down_level,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_led_on,
    output logic [FREQ_W-1:0]     o_frequency,
    output logic                  o_raised,
    output logic                  o_lowered,
    output logic                  o_report_due
);

    logic [LOCK_W-1:0] r_lock_ticks;
    logic [TICK_W-1:0] r_report_int;
    logic [TICK_W-1:0] r_tps;
    logic [FREQ_W-1:0] r_min_f;
    logic [FREQ_W-1:0] r_max_f;

    logic [TICK_W-1:0] r_tick, r_last_toggle, r_last_report;
    logic [FREQ_W-1:0] r_freq;
    logic              r_led;
    logic              r_up_prev, r_dn_prev;
    logic [LOCK_W-1:0] r_up_lock, r_dn_lock;
    logic              r_raised, r_lowered;

    logic [TICK_W-1:0] r_quo;
    logic [REM_W-1:0]  r_rem;

    logic              r_out_valid;

    logic              up_press, dn_press;
    logic [FREQ_W-1:0] freq_up, n_freq;
    logic              up_inc, dn_dec;
    logic [LOCK_W-1:0] up_lock_ld, dn_lock_ld;
    logic [REM_W-1:0]  divisor, rem_sh;
    logic              rem_ge;
    logic [TICK_W-1:0] toggle_elapsed, report_elapsed;
    logic              toggle_hit, report_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_ticks <= LOCK_RST;
            r_report_int <= REPORT_RST;
            r_tps        <= TPS_RST;
            r_min_f      <= MIN_F_RST;
            r_max_f      <= MAX_F_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LOCKOUT:  r_lock_ticks <= i_cfg_wdata[LOCK_W-1:0];
                CFG_REPORT:   r_report_int <= i_cfg_wdata;
                CFG_TPS:      r_tps        <= i_cfg_wdata;
                CFG_MIN_FREQ: r_min_f      <= i_cfg_wdata[FREQ_W-1:0];
                CFG_MAX_FREQ: r_max_f      <= i_cfg_wdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        up_press   = i_up_level & ~r_up_prev & (r_up_lock == '0);
        up_inc     = up_press & (r_freq < r_max_f);
        freq_up    = up_inc ? r_freq + 1'b1 : r_freq;
        up_lock_ld = up_press ? r_lock_ticks : r_up_lock;

        dn_press   = i_down_level & ~r_dn_prev & (r_dn_lock == '0);
        dn_dec     = dn_press & (freq_up > r_min_f) & (freq_up > FREQ_W'(1));
        n_freq     = dn_dec ? freq_up - 1'b1 : freq_up;
        dn_lock_ld = dn_press ? r_lock_ticks : r_dn_lock;
    end

    assign divisor = {1'b0, r_freq, 1'b0};
    assign rem_sh  = {r_rem[REM_W-2:0], r_quo[TICK_W-1]};
    assign rem_ge  = (rem_sh >= divisor);

    assign toggle_elapsed = r_tick - r_last_toggle;
    assign report_elapsed = r_tick - r_last_report;
    assign toggle_hit     = (toggle_elapsed >= r_quo);
    assign report_hit     = (report_elapsed >= r_report_int);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_last_toggle <= '0;
            r_last_report <= '0;
            r_freq        <= FREQ_RST;
            r_led         <= 1'b0;
            r_up_prev     <= 1'b1;
            r_dn_prev     <= 1'b1;
            r_up_lock     <= '0;
            r_dn_lock     <= '0;
        end else if (i_cmd.start) begin
            r_tick    <= r_tick + 1'b1;
            r_freq    <= n_freq;
            r_up_prev <= i_up_level;
            r_dn_prev <= i_down_level;
            r_up_lock <= (up_lock_ld != '0) ? up_lock_ld - 1'b1 : up_lock_ld;
            r_dn_lock <= (dn_lock_ld != '0) ? dn_lock_ld - 1'b1 : dn_lock_ld;
        end else if (i_cmd.finish) begin
            if (toggle_hit) begin
                r_last_toggle <= r_tick;
                r_led         <= ~r_led;
            end
            if (report_hit) begin
                r_last_report <= r_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_raised  <= up_inc;
            r_lowered <= dn_dec;
            r_quo     <= r_tps;
            r_rem     <= '0;
        end else if (i_cmd.step) begin
            r_rem <= rem_ge ? rem_sh - divisor : rem_sh;
            r_quo <= {r_quo[TICK_W-2:0], rem_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_led_on     <= r_led ^ toggle_hit;
            o_frequency  <= r_freq;
            o_raised     <= r_raised;
            o_lowered    <= r_lowered;
            o_report_due <= report_hit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sts.out_busy = r_out_valid & ~i_out_ready;

    `ASSERT_CHK(a_freq_nonzero, (r_freq != '0), "blink frequency reached zero")
    `ASSERT_CHK(a_rem_below_div, i_cmd.step |=> (r_rem < divisor), "divider remainder out of range")

endmodule

/* src/button_tuned_blink_rate_timer.sv */
// An accepted input beat runs 16 divide steps and a finish step before its output
// beat is valid; the finish step waits while the previous output is not yet taken.
// The bit-serial half-period divider takes no new beat until done with the last one.
// A new input beat is taken while the previous result still waits on the output.
// Reset (i_rst_n low, synchronous) loads register defaults, frequency 3, LED off,
// counters and lockouts cleared, and empties the output.
module button_tuned_blink_rate_timer
    import btrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // up_level, down_level, zero pad
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata   // led_on, frequency[7:0], raised, lowered,
                                              // report_due, zero pad
);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic              led_on, raised, lowered, report_due;
    logic [FREQ_W-1:0] frequency;

    btrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    btrt_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_up_level   (i_s_tdata[0]),
        .i_down_level (i_s_tdata[1]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_led_on     (led_on),
        .o_frequency  (frequency),
        .o_raised     (raised),
        .o_lowered    (lowered),
        .o_report_due (report_due)
    );

    assign o_m_tdata = {4'b0000, report_due, lowered, raised, frequency, led_on};

endmodule

/* verif/blink_tick_checker.sv */
module blink_tick_checker
    import btrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // up_level, down_level, zero pad
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,  // led_on, frequency[7:0], raised, lowered,
                                              // report_due, zero pad
    output int unsigned           o_fail_count,
    output int unsigned           o_outstanding
);

    typedef struct packed {
        logic              report_due;
        logic              lowered;
        logic              raised;
        logic [FREQ_W-1:0] frequency;
        logic              led_on;
    } t_blink_beat;

    localparam int BEAT_W = $bits(t_blink_beat);

    logic [LOCK_W-1:0] lock_reload;
    logic [TICK_W-1:0] report_period;
    logic [TICK_W-1:0] tick_rate;
    logic [FREQ_W-1:0] freq_floor;
    logic [FREQ_W-1:0] freq_ceiling;

    logic [TICK_W-1:0] tick_now;
    logic [TICK_W-1:0] toggle_tick;
    logic [TICK_W-1:0] report_tick;
    logic [FREQ_W-1:0] freq;
    logic              led;
    logic              up_prev;
    logic              down_prev;
    logic [LOCK_W-1:0] up_hold;
    logic [LOCK_W-1:0] down_hold;

    t_blink_beat expected_beats[$];
    int unsigned fail_count = 0;
    int unsigned outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    task automatic clear_timer();
        lock_reload   = LOCK_RST;
        report_period = REPORT_RST;
        tick_rate     = TPS_RST;
        freq_floor    = MIN_F_RST;
        freq_ceiling  = MAX_F_RST;
        tick_now      = '0;
        toggle_tick   = '0;
        report_tick   = '0;
        freq          = FREQ_RST;
        led           = 1'b0;
        up_prev       = 1'b1;
        down_prev     = 1'b1;
        up_hold       = '0;
        down_hold     = '0;
    endtask

    task automatic apply_write(input logic [CFG_ADDR_W-1:0] addr,
                               input logic [CFG_DATA_W-1:0] data);
        case (addr)
            CFG_LOCKOUT:  lock_reload   = data[LOCK_W-1:0];
            CFG_REPORT:   report_period = data[TICK_W-1:0];
            CFG_TPS:      tick_rate     = data[TICK_W-1:0];
            CFG_MIN_FREQ: freq_floor    = data[FREQ_W-1:0];
            CFG_MAX_FREQ: freq_ceiling  = data[FREQ_W-1:0];
            default: ;
        endcase
    endtask

    task automatic advance_tick(input logic up, input logic down, output t_blink_beat beat);
        int unsigned       half_period;
        logic [TICK_W-1:0] since_toggle;
        logic [TICK_W-1:0] since_report;
        beat = '0;
        tick_now = tick_now + 1'b1;

        if (up && !up_prev && up_hold == '0) begin
            if (freq < freq_ceiling) begin
                freq = freq + 1'b1;
                beat.raised = 1'b1;
            end
            up_hold = lock_reload;
        end
        if (up_hold != '0) begin
            up_hold = up_hold - 1'b1;
        end
        up_prev = up;

        if (down && !down_prev && down_hold == '0) begin
            if (freq > freq_floor && freq > 8'd1) begin
                freq = freq - 1'b1;
                beat.lowered = 1'b1;
            end
            down_hold = lock_reload;
        end
        if (down_hold != '0) begin
            down_hold = down_hold - 1'b1;
        end
        down_prev = down;

        half_period  = int'(tick_rate) / (2 * int'(freq));
        since_toggle = tick_now - toggle_tick;
        if (since_toggle >= half_period) begin
            toggle_tick = tick_now;
            led = !led;
        end

        since_report = tick_now - report_tick;
        if (since_report >= report_period) begin
            report_tick = tick_now;
            beat.report_due = 1'b1;
        end

        beat.led_on    = led;
        beat.frequency = freq;
    endtask

    always @(posedge i_clk) begin : watch
        t_blink_beat want;
        t_blink_beat got;
        if (!i_rst_n) begin
            clear_timer();
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                apply_write(i_cfg_addr, i_cfg_wdata);
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_tick(i_s_tdata[0], i_s_tdata[1], want);
                expected_beats.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[BEAT_W-1:0];
                if (expected_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected output beat %h with no tick pending", i_m_tdata);
                    end
                end else begin
                    want = expected_beats.pop_front();
                    if (got.led_on !== want.led_on || got.frequency !== want.frequency ||
                        got.raised !== want.raised || got.lowered !== want.lowered ||
                        got.report_due !== want.report_due) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("tick mismatch: expected led %0b freq %0d up %0b dn %0b rpt %0b",
                                     want.led_on, want.frequency, want.raised, want.lowered,
                                     want.report_due);
                            $display("               got      led %0b freq %0d up %0b dn %0b rpt %0b",
                                     got.led_on, got.frequency, got.raised, got.lowered,
                                     got.report_due);
                        end
                    end
                end
            end
        end
        outstanding = expected_beats.size();
    end

endmodule

/* verif/button_tuned_blink_rate_timer_tb.sv */
module button_tuned_blink_rate_timer_tb;
    import btrt_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_TICKS = 1025;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycles = 0;

    bit          gaps_on = 1'b0;
    bit          stalls_on = 1'b0;
    int unsigned stall_left = 0;

    logic        up_lvl = 1'b0;
    logic        down_lvl = 1'b0;
    int unsigned up_run = 0;
    int unsigned down_run = 0;

    button_tuned_blink_rate_timer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    blink_tick_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("button_tuned_blink_rate_timer_tb: FAIL");
            $finish;
        end
    end

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 50);
    endfunction

    always @(negedge clk) begin
        if (!stalls_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = idle_length();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_tick(input logic up, input logic down);
        int unsigned          gap;
        logic [IN_DATA_W-1:0] beat;
        gap = gaps_on ? idle_length() : 0;
        beat = '0;
        beat[0] = up;
        beat[1] = down;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // hold off the sender until every tick has come back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    function automatic int unsigned run_length();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    endfunction

    // button levels held for runs, with occasional single-tick glitches
    task automatic next_levels(output logic up, output logic down);
        if (up_run == 0) begin
            up_lvl = !up_lvl;
            up_run = run_length();
        end
        if (down_run == 0) begin
            down_lvl = !down_lvl;
            down_run = run_length();
        end
        up_run--;
        down_run--;
        up = up_lvl;
        down = down_lvl;
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 1) begin
                up = !up;
            end else begin
                down = !down;
            end
        end
    endtask

    task automatic retune();
        logic [LOCK_W-1:0] lock;
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] rate;
        logic [FREQ_W-1:0] floor_f;
        logic [FREQ_W-1:0] ceil_f;
        logic [7:0]        junk;
        drain();
        case ($urandom_range(0, 5))
            0: lock = '0;
            1: lock = 8'd1;
            2: lock = '1;
            default: lock = LOCK_W'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 5))
            0: period = '0;
            1: period = 16'd1;
            2: period = '1;
            default: period = TICK_W'($urandom_range(1, 200));
        endcase
        case ($urandom_range(0, 5))
            0: rate = 16'd2;
            1: rate = '1;
            default: rate = TICK_W'($urandom_range(2, 300));
        endcase
        case ($urandom_range(0, 4))
            0: floor_f = '0;
            1: floor_f = 8'd1;
            default: floor_f = FREQ_W'($urandom_range(1, 10));
        endcase
        case ($urandom_range(0, 4))
            0: ceil_f = '1;
            1: ceil_f = 8'd1;
            default: ceil_f = FREQ_W'($urandom_range(2, 24));
        endcase
        junk = 8'($urandom);
        write_reg(CFG_LOCKOUT, {junk, lock});
        write_reg(CFG_REPORT, period);
        write_reg(CFG_TPS, rate);
        junk = 8'($urandom);
        write_reg(CFG_MIN_FREQ, {junk, floor_f});
        junk = 8'($urandom);
        write_reg(CFG_MAX_FREQ, {junk, ceil_f});
    endtask

    initial begin
        int unsigned sent;
        int unsigned span;
        logic        up;
        logic        down;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: first pressed tick is no edge
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);

        // no lockout, strobe every tick, half period 0 (1 at frequency 1), zero floor
        drain();
        write_reg(CFG_LOCKOUT, '0);
        write_reg(CFG_REPORT, '0);
        write_reg(CFG_TPS, 16'd2);
        write_reg(CFG_MIN_FREQ, 16'hA500);
        write_reg(CFG_MAX_FREQ, 16'h5A05);
        for (int k = 1; k <= 3; k++) begin
            write_reg(CFG_ADDR_W'(CFG_MAX_FREQ + k), CFG_DATA_W'($urandom));
        end
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        repeat (4) begin
            send_tick(1'b0, 1'b0);
            send_tick(1'b1, 1'b0);
        end
        repeat (5) begin
            send_tick(1'b0, 1'b0);
            send_tick(1'b0, 1'b1);
        end

        // frequency below the floor, then above the ceiling
        drain();
        write_reg(CFG_LOCKOUT, 16'h00FF);
        write_reg(CFG_REPORT, '1);
        write_reg(CFG_TPS, '1);
        write_reg(CFG_MIN_FREQ, 16'd9);
        write_reg(CFG_MAX_FREQ, 16'd255);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        drain();
        write_reg(CFG_LOCKOUT, 16'd1);
        write_reg(CFG_MAX_FREQ, 16'd1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        sent = 0;
        while (sent < RANDOM_TICKS) begin
            retune();
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            span = $urandom_range(80, 160);
            for (int k = 0; k < span && sent < RANDOM_TICKS; k++) begin
                if (k == span / 2 && $urandom_range(0, 2) == 0) begin
                    drain();
                end
                next_levels(up, down);
                send_tick(up, down);
                sent++;
            end
        end

        drain();
        repeat (40) @(negedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("button_tuned_blink_rate_timer_tb: PASS");
        end else begin
            $display("button_tuned_blink_rate_timer_tb: FAIL");
        end
        $finish;
    end

endmodule
